FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the tick scheduler.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
		else $error("assertion failed");
// Check that a condition at one edge implies another at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");
// Check that a condition at one edge implies another at the next edge.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/fpts_pkg.sv
// Constants and types of the fixed-priority tick scheduler.
// No dependencies.
`default_nettype none
package fpts_pkg;
	localparam int MAX_TASKS    = 16;
	localparam int TASK_BITS    = $clog2(MAX_TASKS);
	localparam int CNT_BITS     = $clog2(MAX_TASKS + 1);
	localparam int TIME_BITS    = 16;
	localparam int NEXT_BITS    = TIME_BITS + 1;
	localparam int FIELD_BITS   = 16;
	localparam int BACKLOG_BITS = 24;
	localparam int CFG_BITS     = 16;
	localparam int REG_BITS     = 1;
	localparam int COUNT_BITS   = 5;

	// command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// configuration register indexes
	localparam logic [REG_BITS-1:0] REG_TASK_COUNT  = 1'b0;
	localparam logic [REG_BITS-1:0] REG_HYPERPERIOD = 1'b1;

	typedef struct packed {
		logic [FIELD_BITS-1:0] period;
		logic [FIELD_BITS-1:0] work;
		logic [NEXT_BITS-1:0]  next_rel;
	} task_rec_t;
endpackage
`default_nettype wire

FILE: rtl/fpts_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module fpts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

FILE: rtl/fixed_priority_tick_scheduler.sv
// Fixed-priority preemptive tick scheduler: task records and backlogs in two RAMs.
// Depends on fpts_pkg, fpts_ram and assert_macros.svh.
// A write request leaves busy low, so another request may follow directly.
// A tick request scans the tasks in use (n) through the RAM read port, one per cycle:
// busy stays high until the last entry is updated; the result is registered as busy falls, next request then.
// Reset: task_count 1, hyperperiod 65535, time 0, all backlogs zero (per-entry valid bits).
`default_nettype none
`include "assert_macros.svh"
module fixed_priority_tick_scheduler (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic                                 command,
	input  wire logic [fpts_pkg::TASK_BITS-1:0]       task_index,
	input  wire logic [fpts_pkg::FIELD_BITS-1:0]      period,
	input  wire logic [fpts_pkg::FIELD_BITS-1:0]      first_release,
	input  wire logic [fpts_pkg::FIELD_BITS-1:0]      exec_time,
	output logic                                      result_valid,
	output logic      [fpts_pkg::TIME_BITS-1:0]       tick_time,
	output logic                                      running_valid,
	output logic      [fpts_pkg::TASK_BITS-1:0]       running_task,
	output logic                                      schedule_done,
	output logic                                      schedulable,
	input  wire logic                                 cfg_we,
	input  wire logic [fpts_pkg::REG_BITS-1:0]        cfg_index,
	input  wire logic [fpts_pkg::CFG_BITS-1:0]        cfg_data
);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;
	localparam int   REC_BITS = $bits(fpts_pkg::task_rec_t);

	logic                                state_q;
	logic [fpts_pkg::COUNT_BITS-1:0]     task_count_q;
	logic [fpts_pkg::TIME_BITS-1:0]      hyperperiod_q;
	logic [fpts_pkg::TIME_BITS-1:0]      cur_time_q;
	logic [fpts_pkg::CNT_BITS-1:0]       rd_cnt_q;
	logic                                v_s1;
	logic [fpts_pkg::TASK_BITS-1:0]      idx_s1;
	logic                                active_q;
	logic                                chosen_q;
	logic [fpts_pkg::TASK_BITS-1:0]      chosen_idx_q;
	logic                                nz_q;
	logic [fpts_pkg::MAX_TASKS-1:0]      bl_valid_q;
	logic                                result_valid_q;
	logic [fpts_pkg::TIME_BITS-1:0]      tick_time_q;
	logic                                running_valid_q;
	logic [fpts_pkg::TASK_BITS-1:0]      running_task_q;
	logic                                schedule_done_q;
	logic                                schedulable_q;

	logic [fpts_pkg::CNT_BITS-1:0]       n_tasks;
	logic                                accept;
	logic                                wr_cmd;
	logic                                tick_cmd;
	logic                                issue;
	logic                                finish;
	logic [fpts_pkg::TIME_BITS-1:0]      time_next;
	logic                                done_next;

	fpts_pkg::task_rec_t                 rec_rd;
	fpts_pkg::task_rec_t                 rec_wr;
	fpts_pkg::task_rec_t                 rec_upd;
	logic [REC_BITS-1:0]                 rec_rdata;
	logic                                rec_we;
	logic [fpts_pkg::TASK_BITS-1:0]      rec_waddr;
	logic [fpts_pkg::BACKLOG_BITS-1:0]   bl_rdata;
	logic [fpts_pkg::BACKLOG_BITS-1:0]   bl_cur;
	logic [fpts_pkg::BACKLOG_BITS:0]     bl_sum;
	logic [fpts_pkg::BACKLOG_BITS-1:0]   bl_rel;
	logic [fpts_pkg::BACKLOG_BITS-1:0]   bl_new;
	logic                                release_hit;
	logic                                pick;
	logic                                bl_we;

	assign n_tasks  = (task_count_q > fpts_pkg::COUNT_BITS'(fpts_pkg::MAX_TASKS))
		? fpts_pkg::CNT_BITS'(fpts_pkg::MAX_TASKS) : fpts_pkg::CNT_BITS'(task_count_q);
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign wr_cmd   = accept && (command == fpts_pkg::CMD_WRITE);
	assign tick_cmd = accept && (command == fpts_pkg::CMD_TICK);
	assign issue    = (state_q == ST_SCAN) && (rd_cnt_q < n_tasks);
	assign finish   = (state_q == ST_SCAN) && !issue && !v_s1;

	// Per-entry update: release, then run the first task with backlog in index order.
	assign rec_rd      = fpts_pkg::task_rec_t'(rec_rdata);
	assign bl_cur      = bl_valid_q[idx_s1] ? bl_rdata : '0;
	assign release_hit = active_q && (rec_rd.next_rel == {1'b0, cur_time_q});
	assign bl_sum      = {1'b0, bl_cur}
		+ (release_hit ? (fpts_pkg::BACKLOG_BITS + 1)'(rec_rd.work) : '0);
	assign bl_rel      = bl_sum[fpts_pkg::BACKLOG_BITS] ? '1
		: bl_sum[fpts_pkg::BACKLOG_BITS-1:0];
	assign pick        = active_q && !chosen_q && (bl_rel != '0);
	assign bl_new      = pick ? bl_rel - fpts_pkg::BACKLOG_BITS'(1) : bl_rel;
	assign bl_we       = v_s1 && active_q;

	always_comb begin
		rec_upd          = rec_rd;
		rec_upd.next_rel = rec_rd.next_rel + fpts_pkg::NEXT_BITS'(rec_rd.period);
		rec_wr.period    = period;
		rec_wr.work      = exec_time;
		rec_wr.next_rel  = fpts_pkg::NEXT_BITS'(first_release);
		if (!wr_cmd) begin
			rec_wr = rec_upd;
		end
	end

	assign rec_we    = wr_cmd || (v_s1 && release_hit);
	assign rec_waddr = wr_cmd ? task_index : idx_s1;

	assign time_next = active_q ? cur_time_q + fpts_pkg::TIME_BITS'(1) : cur_time_q;
	assign done_next = (time_next >= hyperperiod_q);

	fpts_ram #(
		.WIDTH(REC_BITS),
		.DEPTH(fpts_pkg::MAX_TASKS)
	) u_rec_ram (
		.clk  (clk),
		.we   (rec_we),
		.waddr(rec_waddr),
		.wdata(rec_wr),
		.raddr(rd_cnt_q[fpts_pkg::TASK_BITS-1:0]),
		.rdata(rec_rdata)
	);

	fpts_ram #(
		.WIDTH(fpts_pkg::BACKLOG_BITS),
		.DEPTH(fpts_pkg::MAX_TASKS)
	) u_backlog_ram (
		.clk  (clk),
		.we   (bl_we),
		.waddr(idx_s1),
		.wdata(bl_new),
		.raddr(rd_cnt_q[fpts_pkg::TASK_BITS-1:0]),
		.rdata(bl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			task_count_q   <= fpts_pkg::COUNT_BITS'(1);
			hyperperiod_q  <= '1;
			cur_time_q     <= '0;
			rd_cnt_q       <= '0;
			v_s1           <= 1'b0;
			active_q       <= 1'b0;
			chosen_q       <= 1'b0;
			nz_q           <= 1'b0;
			bl_valid_q     <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					fpts_pkg::REG_TASK_COUNT: begin
						task_count_q <= cfg_data[fpts_pkg::COUNT_BITS-1:0];
					end
					fpts_pkg::REG_HYPERPERIOD: begin
						hyperperiod_q <= cfg_data[fpts_pkg::TIME_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (bl_we) begin
				bl_valid_q[idx_s1] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (tick_cmd) begin
						state_q  <= ST_SCAN;
						rd_cnt_q <= '0;
						active_q <= (cur_time_q < hyperperiod_q);
						chosen_q <= 1'b0;
						nz_q     <= 1'b0;
					end
				end
				ST_SCAN: begin
					v_s1 <= issue;
					if (issue) begin
						rd_cnt_q <= rd_cnt_q + fpts_pkg::CNT_BITS'(1);
					end
					if (v_s1) begin
						if (pick) begin
							chosen_q <= 1'b1;
						end
						if (bl_new != '0) begin
							nz_q <= 1'b1;
						end
					end
					if (finish) begin
						state_q        <= ST_IDLE;
						cur_time_q     <= time_next;
						result_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: stage index, chosen task and result fields.
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= rd_cnt_q[fpts_pkg::TASK_BITS-1:0];
		end
		if (v_s1 && pick) begin
			chosen_idx_q <= idx_s1;
		end
		if (finish) begin
			tick_time_q     <= cur_time_q;
			running_valid_q <= chosen_q;
			running_task_q  <= chosen_q ? chosen_idx_q : '0;
			schedule_done_q <= done_next;
			schedulable_q   <= done_next && !nz_q;
		end
	end

	assign result_valid  = result_valid_q;
	assign tick_time     = tick_time_q;
	assign running_valid = running_valid_q;
	assign running_task  = running_task_q;
	assign schedule_done = schedule_done_q;
	assign schedulable   = schedulable_q;

	`ASSERT_NEXT(a_tick_goes_busy, clk, arst_n, tick_cmd, busy)
	`ASSERT_IMPLIES(a_strobe_when_idle, clk, arst_n, result_valid_q, !busy)
	`ASSERT_IMPLIES(a_stage_in_scan, clk, arst_n, v_s1, state_q == ST_SCAN)
	`ASSERT_IMPLIES(a_cnt_bound, clk, arst_n, busy, rd_cnt_q <= n_tasks)
	`ASSERT_IMPLIES(a_ran_in_use, clk, arst_n, result_valid_q && running_valid_q,
		fpts_pkg::CNT_BITS'(running_task_q) < n_tasks)
endmodule
`default_nettype wire
